### rtl/core/mpwq_pkg.sv
package mpwq_pkg;

   // pool and queue sizes
   localparam int MUTEX_COUNT_DEFAULT = 2;
   localparam int WAIT_DEPTH_DEFAULT  = 8;

   // stored task id width, equal to the task id port width
   localparam int TASK_ID_BITS = 8;

   // request opcodes
   localparam logic [1:0] OP_CREATE = 2'd0;
   localparam logic [1:0] OP_LOCK   = 2'd1;
   localparam logic [1:0] OP_UNLOCK = 2'd2;

   // response status codes
   localparam logic [1:0] STATUS_OK         = 2'd0;
   localparam logic [1:0] STATUS_NO_FREE    = 2'd1;
   localparam logic [1:0] STATUS_QUEUE_FULL = 2'd2;

   // sequencer states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DESC,
      ST_QUEUE
   } state_type;

   // descriptor memory commands
   typedef struct packed {
      logic rd;
      logic wr;
      logic clr;
   } desc_cmd_type;

endpackage

### rtl/core/mpwq_desc_ram.sv
module mpwq_desc_ram import mpwq_pkg::*; #(
   parameter int MUTEX_COUNT = MUTEX_COUNT_DEFAULT,
   parameter int WAIT_DEPTH  = WAIT_DEPTH_DEFAULT,
   localparam int MUTEX_BITS = (MUTEX_COUNT > 1) ? $clog2(MUTEX_COUNT) : 1,
   localparam int HEAD_W     = (WAIT_DEPTH > 1) ? $clog2(WAIT_DEPTH) : 1,
   localparam int COUNT_W    = $clog2(WAIT_DEPTH + 1)
) (
   input  logic                  clock,
   input  logic                  reset,
   input  desc_cmd_type          cmd,
   input  logic [MUTEX_BITS-1:0] rd_addr,
   input  logic [MUTEX_BITS-1:0] wr_addr,
   input  logic [HEAD_W-1:0]     wr_head,
   input  logic [COUNT_W-1:0]    wr_count,
   output logic [HEAD_W-1:0]     rd_head,
   output logic [COUNT_W-1:0]    rd_count
);

   logic [HEAD_W+COUNT_W-1:0] mem [MUTEX_COUNT];
   logic [HEAD_W+COUNT_W-1:0] rd_data_ff;
   logic [MUTEX_COUNT-1:0]    valid_ff;
   logic                      rd_valid_ff;

   // head and count storage, registered read
   always_ff @(posedge clock) begin
      if (cmd.wr) begin
         mem[wr_addr] <= {wr_head, wr_count};
      end
      if (cmd.rd) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   // entry valid bits, an invalid entry reads as an empty queue
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         if (cmd.wr) begin
            valid_ff[wr_addr] <= 1'b1;
         end
         if (cmd.clr) begin
            valid_ff[wr_addr] <= 1'b0;
         end
         if (cmd.rd) begin
            rd_valid_ff <= valid_ff[rd_addr];
         end
      end
   end

   assign rd_head  = rd_valid_ff ? rd_data_ff[HEAD_W+COUNT_W-1:COUNT_W] : '0;
   assign rd_count = rd_valid_ff ? rd_data_ff[COUNT_W-1:0] : '0;

endmodule

### rtl/core/mpwq_queue_ram.sv
module mpwq_queue_ram import mpwq_pkg::*; #(
   parameter int MUTEX_COUNT = MUTEX_COUNT_DEFAULT,
   parameter int WAIT_DEPTH  = WAIT_DEPTH_DEFAULT,
   localparam int MUTEX_BITS = (MUTEX_COUNT > 1) ? $clog2(MUTEX_COUNT) : 1,
   localparam int HEAD_W     = (WAIT_DEPTH > 1) ? $clog2(WAIT_DEPTH) : 1
) (
   input  logic                    clock,
   input  logic                    wr_en,
   input  logic [MUTEX_BITS-1:0]   wr_mutex,
   input  logic [HEAD_W-1:0]       wr_slot,
   input  logic [TASK_ID_BITS-1:0] wr_data,
   input  logic                    rd_en,
   input  logic [MUTEX_BITS-1:0]   rd_mutex,
   input  logic [HEAD_W-1:0]       rd_slot,
   output logic [TASK_ID_BITS-1:0] rd_data
);

   logic [TASK_ID_BITS-1:0] mem [MUTEX_COUNT][WAIT_DEPTH];
   logic [TASK_ID_BITS-1:0] rd_data_ff;

   // waiting task ids, one ring per mutex
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_mutex][wr_slot] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_mutex][rd_slot];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/core/mutex_pool_with_wait_queues.sv
// Mutex pool with a FIFO wait queue per mutex.
// Requests enter on start/busy: a request transfers at a rising edge with
// start high and busy low, carrying req_opcode (create, lock, unlock),
// req_mutex_index and req_task_id. Each request gives exactly one response,
// shown for one cycle with rsp_valid high; the receiver cannot stall it.
// Response path, counted from the accepting edge:
//   create, unknown opcode, index outside the pool: response registered
//   straight from the request, busy stays low
//   lock, unlock with an empty queue: descriptor memory read, then response
//   unlock handing the mutex to a waiter: descriptor read, then wait queue memory read
// One request is in flight at a time, so a new request waits for the last
// one's response; busy is high while the sequencer is past idle.
// Create picks the lowest mutex neither allocated nor locked.
// Reset clears the allocated and locked flags and the descriptor valid bits,
// so every queue reads empty straight away; no clearing pass is needed and
// the wait queue memory itself is never cleared.
module mutex_pool_with_wait_queues import mpwq_pkg::*; #(
   parameter int MUTEX_COUNT = MUTEX_COUNT_DEFAULT,
   parameter int WAIT_DEPTH  = WAIT_DEPTH_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   output logic       busy,
   input  logic [1:0] req_opcode,
   input  logic       req_mutex_index,
   input  logic [7:0] req_task_id,
   output logic       rsp_valid,
   output logic [1:0] rsp_status,
   output logic       rsp_handle,
   output logic       rsp_must_wait,
   output logic       rsp_woken_valid,
   output logic [7:0] rsp_woken_task
);

   localparam int MUTEX_BITS = (MUTEX_COUNT > 1) ? $clog2(MUTEX_COUNT) : 1;
   localparam int HEAD_W     = (WAIT_DEPTH > 1) ? $clog2(WAIT_DEPTH) : 1;
   localparam int COUNT_W    = $clog2(WAIT_DEPTH + 1);
   localparam int SUM_W      = COUNT_W + 1;

   state_type state_ff, state_in;

   logic [MUTEX_COUNT-1:0] allocated_ff, allocated_in;
   logic [MUTEX_COUNT-1:0] locked_ff, locked_in;

   logic [1:0]            op_ff;
   logic [MUTEX_BITS-1:0] idx_ff;
   logic [7:0]            tid_ff;
   logic                  latch_en;

   logic       rsp_valid_ff, rsp_valid_in;
   logic [1:0] status_ff, status_in;
   logic       handle_ff, handle_in;
   logic       must_wait_ff, must_wait_in;
   logic       woken_valid_ff, woken_valid_in;
   logic [7:0] woken_task_ff, woken_task_in;

   logic                  accept;
   logic                  in_pool;
   logic                  found;
   logic [MUTEX_BITS-1:0] pick;

   desc_cmd_type          desc_cmd;
   logic [MUTEX_BITS-1:0] desc_rd_addr;
   logic [MUTEX_BITS-1:0] desc_wr_addr;
   logic [HEAD_W-1:0]     desc_wr_head;
   logic [COUNT_W-1:0]    desc_wr_count;
   logic [HEAD_W-1:0]     head;
   logic [COUNT_W-1:0]    count;

   logic                    q_wr_en;
   logic                    q_rd_en;
   logic [TASK_ID_BITS-1:0] q_rd_data;

   logic [SUM_W-1:0]  tail_sum;
   logic [HEAD_W-1:0] tail_slot;
   logic [HEAD_W:0]   head_inc;
   logic [HEAD_W-1:0] head_next;
   logic              queue_full;

   assign accept  = start && !busy;
   assign busy    = (state_ff != ST_IDLE);
   assign in_pool = (MUTEX_COUNT > 1) || !req_mutex_index;

   // lowest mutex that is neither allocated nor locked
   always_comb begin
      found = 1'b0;
      pick  = '0;
      for (int i = MUTEX_COUNT - 1; i >= 0; i--) begin
         if (!allocated_ff[i] && !locked_ff[i]) begin
            found = 1'b1;
            pick  = MUTEX_BITS'(i);
         end
      end
   end

   // ring arithmetic on the fetched descriptor
   always_comb begin
      tail_sum  = SUM_W'(head) + SUM_W'(count);
      tail_slot = (tail_sum >= SUM_W'(WAIT_DEPTH)) ? HEAD_W'(tail_sum - SUM_W'(WAIT_DEPTH))
                                                   : HEAD_W'(tail_sum);
      head_inc  = (HEAD_W + 1)'(head) + 1'b1;
      head_next = (head_inc == (HEAD_W + 1)'(WAIT_DEPTH)) ? '0 : HEAD_W'(head_inc);
      queue_full = (count >= COUNT_W'(WAIT_DEPTH));
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept && in_pool && (req_opcode == OP_LOCK || req_opcode == OP_UNLOCK)) begin
               state_in = ST_DESC;
            end
         end
         ST_DESC: begin
            if (op_ff == OP_UNLOCK && count != '0) begin
               state_in = ST_QUEUE;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_QUEUE: state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   // memory commands, flag updates and response values
   always_comb begin
      latch_en       = 1'b0;
      desc_cmd       = '0;
      desc_rd_addr   = MUTEX_BITS'(req_mutex_index);
      desc_wr_addr   = idx_ff;
      desc_wr_head   = head;
      desc_wr_count  = count;
      q_wr_en        = 1'b0;
      q_rd_en        = 1'b0;
      allocated_in   = allocated_ff;
      locked_in      = locked_ff;
      rsp_valid_in   = 1'b0;
      status_in      = STATUS_OK;
      handle_in      = 1'b0;
      must_wait_in   = 1'b0;
      woken_valid_in = 1'b0;
      woken_task_in  = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               latch_en = 1'b1;
               case (req_opcode) inside
                  OP_CREATE: begin
                     rsp_valid_in = 1'b1;
                     if (found) begin
                        allocated_in[pick] = 1'b1;
                        desc_cmd.clr       = 1'b1;
                        desc_wr_addr       = pick;
                        handle_in          = pick[0];
                     end else begin
                        status_in = STATUS_NO_FREE;
                     end
                  end
                  OP_LOCK, OP_UNLOCK: begin
                     if (in_pool) begin
                        desc_cmd.rd = 1'b1;
                     end else begin
                        rsp_valid_in = 1'b1;
                     end
                  end
                  default: rsp_valid_in = 1'b1;
               endcase
            end
         end
         ST_DESC: begin
            if (op_ff == OP_LOCK) begin
               rsp_valid_in      = 1'b1;
               locked_in[idx_ff] = 1'b1;
               if (locked_ff[idx_ff]) begin
                  if (queue_full) begin
                     status_in = STATUS_QUEUE_FULL;
                  end else begin
                     q_wr_en       = 1'b1;
                     desc_cmd.wr   = 1'b1;
                     desc_wr_count = count + 1'b1;
                     must_wait_in  = 1'b1;
                  end
               end
            end else if (count == '0) begin
               rsp_valid_in      = 1'b1;
               locked_in[idx_ff] = 1'b0;
            end else begin
               q_rd_en       = 1'b1;
               desc_cmd.wr   = 1'b1;
               desc_wr_head  = head_next;
               desc_wr_count = count - 1'b1;
            end
         end
         ST_QUEUE: begin
            rsp_valid_in   = 1'b1;
            woken_valid_in = 1'b1;
            woken_task_in  = q_rd_data;
         end
         default: begin
            rsp_valid_in = 1'b0;
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         allocated_ff <= '0;
         locked_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         allocated_ff <= allocated_in;
         locked_ff    <= locked_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // request capture and response payload
   always_ff @(posedge clock) begin
      if (latch_en) begin
         op_ff  <= req_opcode;
         idx_ff <= MUTEX_BITS'(req_mutex_index);
         tid_ff <= req_task_id;
      end
      status_ff      <= status_in;
      handle_ff      <= handle_in;
      must_wait_ff   <= must_wait_in;
      woken_valid_ff <= woken_valid_in;
      woken_task_ff  <= woken_task_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = status_ff;
   assign rsp_handle      = handle_ff;
   assign rsp_must_wait   = must_wait_ff;
   assign rsp_woken_valid = woken_valid_ff;
   assign rsp_woken_task  = woken_task_ff;

   mpwq_desc_ram #(
      .MUTEX_COUNT(MUTEX_COUNT),
      .WAIT_DEPTH (WAIT_DEPTH)
   ) u_desc_ram (
      .clock   (clock),
      .reset   (reset),
      .cmd     (desc_cmd),
      .rd_addr (desc_rd_addr),
      .wr_addr (desc_wr_addr),
      .wr_head (desc_wr_head),
      .wr_count(desc_wr_count),
      .rd_head (head),
      .rd_count(count)
   );

   mpwq_queue_ram #(
      .MUTEX_COUNT(MUTEX_COUNT),
      .WAIT_DEPTH (WAIT_DEPTH)
   ) u_queue_ram (
      .clock   (clock),
      .wr_en   (q_wr_en),
      .wr_mutex(idx_ff),
      .wr_slot (tail_slot),
      .wr_data (tid_ff),
      .rd_en   (q_rd_en),
      .rd_mutex(idx_ff),
      .rd_slot (head),
      .rd_data (q_rd_data)
   );

`ifndef ASSERT_OFF
   // a fetched descriptor always leads to a response or a queue read
   a_desc_resolves: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DESC) |=> (rsp_valid || state_ff == ST_QUEUE))
      else $error("descriptor stage left without response or queue read");

   // the queue read stage only follows the descriptor stage
   a_queue_after_desc: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_QUEUE) |-> $past(state_ff == ST_DESC))
      else $error("queue read stage entered out of order");

   // a woken waiter is only reported after a queue read
   a_woken_from_queue: assert property (@(posedge clock) disable iff (reset)
      rsp_woken_valid |-> (rsp_valid && $past(state_ff == ST_QUEUE)))
      else $error("woken task reported without queue read");

   // a queued waiter always leaves its mutex locked
   a_wait_keeps_lock: assert property (@(posedge clock) disable iff (reset)
      (rsp_must_wait && rsp_valid) |-> locked_ff[idx_ff])
      else $error("task queued on an unlocked mutex");

   // no new request while a descriptor fetch is pending
   a_busy_while_fetch: assert property (@(posedge clock) disable iff (reset)
      desc_cmd.rd |=> busy)
      else $error("request accepted during descriptor fetch");
`endif

endmodule

### dv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
   import mpwq_pkg::*;

   localparam int N_MUTEX   = MUTEX_COUNT_DEFAULT;
   localparam int Q_DEPTH   = WAIT_DEPTH_DEFAULT;
   localparam int PHASE_LEN = 325;
   localparam int N_DIR     = 25;

   // the one opcode the package leaves unnamed
   localparam logic [1:0] OP_UNKNOWN = 2'd3;

   typedef struct packed {
      logic [1:0] status;
      logic       handle;
      logic       must_wait;
      logic       woken_valid;
      logic [7:0] woken_task;
   } mutex_rsp_type;

   typedef struct packed {
      logic [1:0] opcode;
      logic       mutex_index;
      logic [7:0] task_id;
      logic       fixed_rsp;
      logic [1:0] status;
      logic       handle;
      logic       must_wait;
      logic       woken_valid;
      logic [7:0] woken_task;
   } dir_row_type;

   logic       clock;
   logic       reset;
   logic       start;
   logic       busy;
   logic [1:0] req_opcode;
   logic       req_mutex_index;
   logic [7:0] req_task_id;
   logic       rsp_valid;
   logic [1:0] rsp_status;
   logic       rsp_handle;
   logic       rsp_must_wait;
   logic       rsp_woken_valid;
   logic [7:0] rsp_woken_task;

   // mirror of the pool state
   logic        mx_alloc   [N_MUTEX];
   logic        mx_locked  [N_MUTEX];
   logic [7:0]  mx_waiters [N_MUTEX][Q_DEPTH];
   int unsigned mx_head    [N_MUTEX];
   int unsigned mx_count   [N_MUTEX];

   mutex_rsp_type pending_rsp [$];
   int            fail_count = 0;
   int            idle_pct   = 0;

   // directed sequence: fixed responses where they are obvious
   dir_row_type dir_table [N_DIR] = '{
      // unlock of an unlocked mutex, lock of an unallocated one
      '{OP_UNLOCK,  1'b1, 8'h00, 1'b1, STATUS_OK,         1'b0, 1'b0, 1'b0, 8'h00},
      '{OP_LOCK,    1'b1, 8'h12, 1'b1, STATUS_OK,         1'b0, 1'b0, 1'b0, 8'h00},
      // locked mutex is not free for create
      '{OP_CREATE,  1'b1, 8'hFF, 1'b1, STATUS_OK,         1'b0, 1'b0, 1'b0, 8'h00},
      '{OP_CREATE,  1'b0, 8'h00, 1'b1, STATUS_NO_FREE,    1'b0, 1'b0, 1'b0, 8'h00},
      '{OP_UNLOCK,  1'b1, 8'h00, 1'b1, STATUS_OK,         1'b0, 1'b0, 1'b0, 8'h00},
      '{OP_CREATE,  1'b0, 8'h00, 1'b1, STATUS_OK,         1'b1, 1'b0, 1'b0, 8'h00},
      // fill the wait queue of mutex 0 and overflow it
      '{OP_LOCK,    1'b0, 8'h00, 1'b1, STATUS_OK,         1'b0, 1'b0, 1'b0, 8'h00},
      '{OP_LOCK,    1'b0, 8'hFF, 1'b1, STATUS_OK,         1'b0, 1'b1, 1'b0, 8'h00},
      '{OP_LOCK,    1'b0, 8'hA5, 1'b0, STATUS_OK,         1'b0, 1'b0, 1'b0, 8'h00},
      '{OP_LOCK,    1'b0, 8'h5A, 1'b0, STATUS_OK,         1'b0, 1'b0, 1'b0, 8'h00},
      '{OP_LOCK,    1'b0, 8'h01, 1'b0, STATUS_OK,         1'b0, 1'b0, 1'b0, 8'h00},
      '{OP_LOCK,    1'b0, 8'h80, 1'b0, STATUS_OK,         1'b0, 1'b0, 1'b0, 8'h00},
      '{OP_LOCK,    1'b0, 8'h7F, 1'b0, STATUS_OK,         1'b0, 1'b0, 1'b0, 8'h00},
      '{OP_LOCK,    1'b0, 8'hFE, 1'b0, STATUS_OK,         1'b0, 1'b0, 1'b0, 8'h00},
      '{OP_LOCK,    1'b0, 8'h33, 1'b0, STATUS_OK,         1'b0, 1'b0, 1'b0, 8'h00},
      '{OP_LOCK,    1'b0, 8'h44, 1'b1, STATUS_QUEUE_FULL, 1'b0, 1'b0, 1'b0, 8'h00},
      '{OP_UNKNOWN, 1'b1, 8'hFF, 1'b1, STATUS_OK,         1'b0, 1'b0, 1'b0, 8'h00},
      // hand over to the oldest waiter, then wrap the ring
      '{OP_UNLOCK,  1'b0, 8'h00, 1'b1, STATUS_OK,         1'b0, 1'b0, 1'b1, 8'hFF},
      '{OP_LOCK,    1'b0, 8'h10, 1'b0, STATUS_OK,         1'b0, 1'b0, 1'b0, 8'h00},
      '{OP_UNLOCK,  1'b0, 8'h00, 1'b0, STATUS_OK,         1'b0, 1'b0, 1'b0, 8'h00},
      // mutex 1 with a single waiter
      '{OP_LOCK,    1'b1, 8'hC3, 1'b0, STATUS_OK,         1'b0, 1'b0, 1'b0, 8'h00},
      '{OP_LOCK,    1'b1, 8'h3C, 1'b0, STATUS_OK,         1'b0, 1'b0, 1'b0, 8'h00},
      '{OP_UNLOCK,  1'b1, 8'h00, 1'b0, STATUS_OK,         1'b0, 1'b0, 1'b0, 8'h00},
      '{OP_UNLOCK,  1'b1, 8'h00, 1'b0, STATUS_OK,         1'b0, 1'b0, 1'b0, 8'h00},
      '{OP_UNKNOWN, 1'b0, 8'h00, 1'b1, STATUS_OK,         1'b0, 1'b0, 1'b0, 8'h00}
   };

   mutex_pool_with_wait_queues dut (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_opcode      (req_opcode),
      .req_mutex_index (req_mutex_index),
      .req_task_id     (req_task_id),
      .rsp_valid       (rsp_valid),
      .rsp_status      (rsp_status),
      .rsp_handle      (rsp_handle),
      .rsp_must_wait   (rsp_must_wait),
      .rsp_woken_valid (rsp_woken_valid),
      .rsp_woken_task  (rsp_woken_task)
   );

   // clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // run limit
   initial begin
      #2_000_000;
      $display("[mutex_pool_with_wait_queues] ERROR");
      $finish;
   end

   // applies one request to the mirrored pool and returns its response
   function automatic mutex_rsp_type apply_mutex_request(input logic [1:0] op,
                                                         input logic idx,
                                                         input logic [7:0] tid);
      mutex_rsp_type r;
      bit            found;
      int unsigned   slot;
      r = '0;
      found = 1'b0;
      case (op)
         OP_CREATE: begin
            for (int i = 0; i < N_MUTEX; i++) begin
               if (!found && !mx_alloc[i] && !mx_locked[i]) begin
                  mx_alloc[i] = 1'b1;
                  mx_head[i]  = 0;
                  mx_count[i] = 0;
                  r.handle    = 1'(i);
                  found       = 1'b1;
               end
            end
            if (!found) r.status = STATUS_NO_FREE;
         end
         OP_LOCK: begin
            if (mx_locked[idx]) begin
               if (mx_count[idx] >= Q_DEPTH) begin
                  r.status = STATUS_QUEUE_FULL;
               end else begin
                  slot = (mx_head[idx] + mx_count[idx]) % Q_DEPTH;
                  mx_waiters[idx][slot] = tid;
                  mx_count[idx]++;
                  r.must_wait = 1'b1;
               end
            end
            mx_locked[idx] = 1'b1;
         end
         OP_UNLOCK: begin
            if (mx_count[idx] == 0) begin
               mx_locked[idx] = 1'b0;
            end else begin
               r.woken_valid = 1'b1;
               r.woken_task  = mx_waiters[idx][mx_head[idx]];
               mx_head[idx]  = (mx_head[idx] + 1) % Q_DEPTH;
               mx_count[idx]--;
            end
         end
         default: ;
      endcase
      return r;
   endfunction

   // one request transfer, with an optional idle gap in front of it
   task automatic issue_request(input logic [1:0] op, input logic idx,
                                input logic [7:0] tid, input bit use_fixed,
                                input mutex_rsp_type fixed_val);
      mutex_rsp_type model_rsp;
      if ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      start           <= 1'b1;
      req_opcode      <= op;
      req_mutex_index <= idx;
      req_task_id     <= tid;
      do @(posedge clock); while (!(start && !busy));
      model_rsp = apply_mutex_request(op, idx, tid);
      pending_rsp.push_back(use_fixed ? fixed_val : model_rsp);
   endtask

   // response checker
   always @(posedge clock) begin
      mutex_rsp_type want;
      if (!reset && rsp_valid === 1'b1) begin
         if (pending_rsp.size() == 0) begin
            $error("response transfer with nothing outstanding");
            fail_count++;
         end else begin
            want = pending_rsp.pop_front();
            if (rsp_status !== want.status) begin
               $error("status: expected %0d, got %0d", want.status, rsp_status);
               fail_count++;
            end
            if (rsp_handle !== want.handle) begin
               $error("handle: expected %0d, got %0d", want.handle, rsp_handle);
               fail_count++;
            end
            if (rsp_must_wait !== want.must_wait) begin
               $error("must_wait: expected %0d, got %0d", want.must_wait, rsp_must_wait);
               fail_count++;
            end
            if (rsp_woken_valid !== want.woken_valid) begin
               $error("woken_valid: expected %0d, got %0d",
                      want.woken_valid, rsp_woken_valid);
               fail_count++;
            end
            if (rsp_woken_task !== want.woken_task) begin
               $error("woken_task: expected 0x%02h, got 0x%02h",
                      want.woken_task, rsp_woken_task);
               fail_count++;
            end
         end
      end
   end

   // stimulus
   initial begin
      int            phase_idle [4];
      int            run_left;
      int            pick;
      bit            filling;
      logic          fav_idx;
      logic [1:0]    op;
      logic          idx;
      mutex_rsp_type row_rsp;

      // sender idle percentage per phase: none, 51, none, 19
      phase_idle = '{0, 51, 0, 19};

      reset           <= 1'b1;
      start           <= 1'b0;
      req_opcode      <= OP_CREATE;
      req_mutex_index <= 1'b0;
      req_task_id     <= 8'h00;
      for (int m = 0; m < N_MUTEX; m++) begin
         mx_alloc[m]  = 1'b0;
         mx_locked[m] = 1'b0;
         mx_head[m]   = 0;
         mx_count[m]  = 0;
      end
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // directed table
      idle_pct = 19;
      foreach (dir_table[i]) begin
         row_rsp = '{dir_table[i].status, dir_table[i].handle, dir_table[i].must_wait,
                     dir_table[i].woken_valid, dir_table[i].woken_task};
         issue_request(dir_table[i].opcode, dir_table[i].mutex_index,
                       dir_table[i].task_id, dir_table[i].fixed_rsp, row_rsp);
      end

      // random part: alternating fill and drain runs on a favoured mutex
      run_left = 0;
      filling  = 1'b0;
      fav_idx  = 1'b0;
      foreach (phase_idle[p]) begin
         idle_pct = phase_idle[p];
         repeat (PHASE_LEN) begin
            if (run_left == 0) begin
               filling  = ~filling;
               run_left = $urandom_range(4, 30);
               fav_idx  = 1'($urandom_range(1));
            end
            run_left--;
            pick = $urandom_range(99);
            if (pick < 6)
               op = OP_CREATE;
            else if (pick < 10)
               op = OP_UNKNOWN;
            else if (pick < (filling ? 75 : 30))
               op = OP_LOCK;
            else
               op = OP_UNLOCK;
            idx = ($urandom_range(99) < 80) ? fav_idx : ~fav_idx;
            issue_request(op, idx, 8'($urandom_range(255)), 1'b0, '0);
         end
      end
      start <= 1'b0;

      // drain outstanding responses
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (fail_count == 0) begin
         $display("[mutex_pool_with_wait_queues] OK");
      end else begin
         $display("[mutex_pool_with_wait_queues] ERROR");
      end
      $finish;
   end

endmodule
